### rtl/gnsd_pkg.sv
`default_nettype none
package gnsd_pkg;

  localparam int unsigned MaxStepsDef = 1024;
  localparam int unsigned FracBitsDef = 16;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CoefW    = 31;
  localparam int unsigned ElapsedW = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned SatW     = 68;

  // Reciprocal of 1000 scaled by 2^41; exact truncation for magnitudes up to 2^31
  localparam logic signed [32:0] Recip1000  = 33'sd2199023256;
  localparam int unsigned        RecipShift = 41;

  localparam logic signed [DataW-1:0] InitAngleRst = 32'sd0;
  localparam logic signed [DataW-1:0] LastAngleRst = 32'sd17694720;
  localparam logic signed [DataW-1:0] MinValueRst  = 32'sd0;
  localparam logic signed [DataW-1:0] MaxValueRst  = 32'sd65536;
  localparam logic                    StopPinRst   = 1'b1;
  localparam logic [CoefW-1:0]        NatFreqRst   = 31'd0;
  localparam logic [CoefW-1:0]        DampRst      = 31'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INITIAL_ANGLE = 3'd0,
    REG_LAST_ANGLE    = 3'd1,
    REG_MINIMUM_VALUE = 3'd2,
    REG_MAXIMUM_VALUE = 3'd3,
    REG_STOP_PIN      = 3'd4,
    REG_NATURAL_FREQ  = 3'd5,
    REG_DAMPING_RATIO = 3'd6
  } gnsd_reg_e;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    hi = SatW'(32'sh7fffffff);
    lo = -SatW'(33'sh080000000);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] clamp_ends(input logic signed [DataW-1:0] a,
                                                         input logic signed [DataW-1:0] e0,
                                                         input logic signed [DataW-1:0] e1);
    logic signed [DataW-1:0] lo;
    logic signed [DataW-1:0] hi;
    lo = (e0 < e1) ? e0 : e1;
    hi = (e0 < e1) ? e1 : e0;
    if (a < lo) begin
      return lo;
    end else if (a > hi) begin
      return hi;
    end
    return a;
  endfunction

endpackage
`default_nettype wire

### rtl/gnsd_in_if.sv
`default_nettype none
interface gnsd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gnsd_pkg::DataW-1:0]      measured_value;
  logic        [gnsd_pkg::ElapsedW-1:0]   elapsed_ms;

  modport source (output valid, output measured_value, output elapsed_ms, input ready);
  modport sink   (input valid, input measured_value, input elapsed_ms, output ready);
endinterface
`default_nettype wire

### rtl/gnsd_out_if.sv
`default_nettype none
interface gnsd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gnsd_pkg::DataW-1:0] needle_angle;

  modport source (output valid, output needle_angle, input ready);
  modport sink   (input valid, input needle_angle, output ready);
endinterface
`default_nettype wire

### rtl/gauge_needle_spring_damper.sv
`default_nettype none
// Channel   Dir  Payload                              Handshake
// in_i      in   measured_value[31:0], elapsed_ms[10:0]  valid/ready
// out_o     out  needle_angle[31:0]                   valid/ready
// cfg       in   cfg_we_i, cfg_idx_i[2:0], cfg_data_i[31:0]  write only
//
// One transaction at a time: accept, then the scale divider in ST_DIV and the
// mapping multiply (both skipped on a zero value span), the spring coefficients
// (skipped with all steps on a zero natural frequency), then M1 to XUPD per
// millisecond step on the shared 33x33 multiplier, and ST_OUT to finish.
// Reset is asynchronous; it loads config defaults and clears velocity, position and control.
// A result held on out_o stalls only the following result, which waits in ST_OUT.
module gauge_needle_spring_damper #(
  parameter int unsigned MAX_STEPS = gnsd_pkg::MaxStepsDef,
  parameter int unsigned FRAC_BITS = gnsd_pkg::FracBitsDef
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  gnsd_in_if.sink                             in_i,
  gnsd_out_if.source                          out_o,
  input  wire                                 cfg_we_i,
  input  wire [gnsd_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire [gnsd_pkg::DataW-1:0]           cfg_data_i
);

  localparam int unsigned DW   = gnsd_pkg::DataW;
  localparam int unsigned SW   = $clog2(MAX_STEPS + 1);
  localparam int unsigned EW   = gnsd_pkg::ElapsedW;
  localparam int unsigned CMPW = (SW > EW) ? SW : EW;
  localparam int unsigned NW   = 33 + FRAC_BITS;
  localparam int unsigned DCW  = $clog2(NW + 1);
  localparam int unsigned PW   = 66;
  localparam int unsigned TW   = PW - FRAC_BITS;
  localparam int unsigned QW   = PW - 1 - gnsd_pkg::RecipShift;
  localparam int unsigned SATW = gnsd_pkg::SatW;

  typedef enum logic [15:0] {
    ST_IDLE = 16'b0000_0000_0000_0001,
    ST_DIV  = 16'b0000_0000_0000_0010,
    ST_RAT  = 16'b0000_0000_0000_0100,
    ST_TMUL = 16'b0000_0000_0000_1000,
    ST_TGT  = 16'b0000_0000_0001_0000,
    ST_WW   = 16'b0000_0000_0010_0000,
    ST_CW   = 16'b0000_0000_0100_0000,
    ST_CW2  = 16'b0000_0000_1000_0000,
    ST_M1   = 16'b0000_0001_0000_0000,
    ST_M2   = 16'b0000_0010_0000_0000,
    ST_ACC  = 16'b0000_0100_0000_0000,
    ST_D1   = 16'b0000_1000_0000_0000,
    ST_VUPD = 16'b0001_0000_0000_0000,
    ST_D2   = 16'b0010_0000_0000_0000,
    ST_XUPD = 16'b0100_0000_0000_0000,
    ST_OUT  = 16'b1000_0000_0000_0000
  } gnsd_state_e;

  gnsd_state_e state_q, state_d;

  // configuration
  logic signed [DW-1:0]           init_q, last_q, min_q, max_q;
  logic                           stop_q;
  logic [gnsd_pkg::CoefW-1:0]     wn_q, zeta_q;

  // datapath
  logic signed [DW-1:0]  value_q;
  logic [SW-1:0]         steps_q;
  logic [NW-1:0]         num_q;
  logic [33:0]           rem_q;
  logic [32:0]           den_q;
  logic                  qneg_q;
  logic [DCW-1:0]        div_cnt_q;
  logic signed [DW-1:0]  ratio_q, target_q, ww_q, cw2_q, err_q, acc_q;
  logic signed [DW-1:0]  vel_q, pos_q, angle_q;
  logic signed [TW-1:0]  t1_q;
  logic signed [PW-1:0]  prod_q;
  logic signed [32:0]    mul_a, mul_b;
  logic                  out_valid_q;
  logic signed [DW-1:0]  out_angle_q;

  logic                  in_acc;
  logic signed [32:0]    span_v, span_a;
  logic [32:0]           span_v_mag, span_a_mag;
  logic [CMPW-1:0]       el_ext;
  logic [33:0]           trial;
  logic                  trial_ge;
  logic signed [DW-1:0]  tgt_raw, tgt_fin;
  logic signed [PW-1:0]  prod_sh;
  logic [QW-1:0]         quo;
  logic signed [SATW-1:0] quo_s;
  logic                  out_load;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.needle_angle = out_angle_q;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  assign span_v = 33'(max_q) - 33'(min_q);
  assign span_a = 33'(last_q) - 33'(init_q);
  assign span_v_mag = span_v[32] ? (~span_v + 33'd1) : span_v;
  assign span_a_mag = span_a[32] ? (~span_a + 33'd1) : span_a;
  assign el_ext = CMPW'(in_i.elapsed_ms);

  assign trial    = {rem_q[32:0], num_q[NW-1]} - {1'b0, den_q};
  assign trial_ge = !trial[33];

  assign prod_sh = prod_q >>> FRAC_BITS;
  assign quo     = prod_q[PW-2:gnsd_pkg::RecipShift];
  assign quo_s   = SATW'({1'b0, quo});

  assign tgt_raw = (state_q == ST_IDLE) ? init_q
                 : gnsd_pkg::sat32(SATW'(prod_sh) + SATW'(init_q));
  assign tgt_fin = stop_q ? gnsd_pkg::clamp_ends(tgt_raw, init_q, last_q) : tgt_raw;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_TMUL: begin
        mul_a = 33'(value_q) - 33'(min_q);
        mul_b = 33'(ratio_q);
      end
      ST_WW: begin
        mul_a = $signed({2'b00, wn_q});
        mul_b = $signed({2'b00, wn_q});
      end
      ST_CW: begin
        mul_a = $signed({2'b00, zeta_q});
        mul_b = $signed({2'b00, wn_q});
      end
      ST_M1: begin
        mul_a = 33'(cw2_q);
        mul_b = 33'(vel_q);
      end
      ST_M2: begin
        mul_a = 33'(ww_q);
        mul_b = 33'(err_q);
      end
      ST_D1: begin
        mul_a = acc_q[DW-1] ? -33'(acc_q) : 33'(acc_q);
        mul_b = gnsd_pkg::Recip1000;
      end
      ST_D2: begin
        mul_a = vel_q[DW-1] ? -33'(vel_q) : 33'(vel_q);
        mul_b = gnsd_pkg::Recip1000;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (span_v == '0) begin
            state_d = (wn_q != '0) ? ST_WW : ST_OUT;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV:  state_d = (div_cnt_q == DCW'(1)) ? ST_RAT : ST_DIV;
      ST_RAT:  state_d = ST_TMUL;
      ST_TMUL: state_d = ST_TGT;
      ST_TGT:  state_d = (wn_q != '0) ? ST_WW : ST_OUT;
      ST_WW:   state_d = ST_CW;
      ST_CW:   state_d = ST_CW2;
      ST_CW2:  state_d = (steps_q != '0) ? ST_M1 : ST_OUT;
      ST_M1:   state_d = ST_M2;
      ST_M2:   state_d = ST_ACC;
      ST_ACC:  state_d = ST_D1;
      ST_D1:   state_d = ST_VUPD;
      ST_VUPD: state_d = ST_D2;
      ST_D2:   state_d = ST_XUPD;
      ST_XUPD: state_d = (steps_q == SW'(1)) ? ST_OUT : ST_M1;
      ST_OUT:  state_d = out_load ? ST_IDLE : ST_OUT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      init_q      <= gnsd_pkg::InitAngleRst;
      last_q      <= gnsd_pkg::LastAngleRst;
      min_q       <= gnsd_pkg::MinValueRst;
      max_q       <= gnsd_pkg::MaxValueRst;
      stop_q      <= gnsd_pkg::StopPinRst;
      wn_q        <= gnsd_pkg::NatFreqRst;
      zeta_q      <= gnsd_pkg::DampRst;
      vel_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
      steps_q     <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (gnsd_pkg::gnsd_reg_e'(cfg_idx_i))
          gnsd_pkg::REG_INITIAL_ANGLE: init_q <= cfg_data_i;
          gnsd_pkg::REG_LAST_ANGLE:    last_q <= cfg_data_i;
          gnsd_pkg::REG_MINIMUM_VALUE: min_q  <= cfg_data_i;
          gnsd_pkg::REG_MAXIMUM_VALUE: max_q  <= cfg_data_i;
          gnsd_pkg::REG_STOP_PIN:      stop_q <= cfg_data_i[0];
          gnsd_pkg::REG_NATURAL_FREQ:  wn_q   <= cfg_data_i[gnsd_pkg::CoefW-1:0];
          gnsd_pkg::REG_DAMPING_RATIO: zeta_q <= cfg_data_i[gnsd_pkg::CoefW-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        steps_q <= (el_ext > CMPW'(MAX_STEPS)) ? SW'(MAX_STEPS) : SW'(el_ext);
      end else if (state_q == ST_XUPD) begin
        steps_q <= steps_q - SW'(1);
      end

      if (in_acc) begin
        div_cnt_q <= DCW'(NW);
      end else if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q - DCW'(1);
      end

      if (state_q == ST_VUPD) begin
        vel_q <= gnsd_pkg::sat32(SATW'(vel_q) + (acc_q[DW-1] ? -quo_s : quo_s));
      end
      if (state_q == ST_XUPD) begin
        pos_q <= gnsd_pkg::sat32(SATW'(pos_q) + (vel_q[DW-1] ? -quo_s : quo_s));
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;

    if (in_acc) begin
      value_q  <= in_i.measured_value;
      den_q    <= span_v_mag;
      num_q    <= NW'(span_a_mag) << FRAC_BITS;
      rem_q    <= '0;
      qneg_q   <= span_a[32] ^ span_v[32];
      target_q <= tgt_fin;
      angle_q  <= tgt_fin;
    end

    if (state_q == ST_DIV) begin
      rem_q <= trial_ge ? trial : {rem_q[32:0], num_q[NW-1]};
      num_q <= {num_q[NW-2:0], trial_ge};
    end

    if (state_q == ST_RAT) begin
      if (num_q > NW'(32'h7fffffff)) begin
        ratio_q <= qneg_q ? -32'sh7fffffff : 32'sh7fffffff;
      end else begin
        ratio_q <= qneg_q ? -$signed({1'b0, num_q[DW-2:0]}) : $signed({1'b0, num_q[DW-2:0]});
      end
    end

    if (state_q == ST_TGT) begin
      target_q <= tgt_fin;
      angle_q  <= tgt_fin;
    end

    if (state_q == ST_CW) begin
      ww_q <= gnsd_pkg::sat32(SATW'(prod_sh));
    end
    if (state_q == ST_CW2) begin
      cw2_q <= gnsd_pkg::sat32(SATW'(prod_sh) <<< 1);
      angle_q <= stop_q ? gnsd_pkg::clamp_ends(pos_q, init_q, last_q) : pos_q;
    end

    if (state_q == ST_M1) begin
      err_q <= gnsd_pkg::sat32(SATW'(pos_q) - SATW'(target_q));
    end
    if (state_q == ST_M2) begin
      t1_q <= prod_sh[TW-1:0];
    end
    if (state_q == ST_ACC) begin
      acc_q <= gnsd_pkg::sat32(-SATW'(t1_q) - SATW'(prod_sh));
    end

    // position after each step, clamped for display only when stop_q is set
    if (state_q == ST_XUPD) begin
      angle_q <= stop_q
        ? gnsd_pkg::clamp_ends(gnsd_pkg::sat32(SATW'(pos_q) + (vel_q[DW-1] ? -quo_s : quo_s)),
                               init_q, last_q)
        : gnsd_pkg::sat32(SATW'(pos_q) + (vel_q[DW-1] ? -quo_s : quo_s));
    end

    if (out_load) begin
      out_angle_q <= angle_q;
    end
  end

endmodule
`default_nettype wire
